### hdl/msp_pkg.sv
package msp_pkg;

    // Default sizes of the pool
    localparam int NUM_STACKS_DEF = 8;
    localparam int CAPACITY_DEF   = 256;

    // Fixed payload widths
    localparam int DATA_W   = 32;
    localparam int SIDX_W   = 3;
    localparam int STATUS_W = 2;

    // Operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Sequencer states, one-hot
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

endpackage

### hdl/msp_ram.sv
module msp_ram #(
    parameter int WIDTH = msp_pkg::DATA_W,
    parameter int DEPTH = msp_pkg::CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds its data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/multi_stack_shared_pool_top.sv
// Several LIFO stacks sharing one pool of slots, linked through a free list.
//
// Input channel (i_in_valid / o_in_ready): one item is a push of i_push_value
// onto stack i_stack_index (i_operation = 0) or a pop of that stack
// (i_operation = 1). Output channel (o_out_valid / i_out_ready): one result
// item per input item, o_status (done, pool full, stack empty) and
// o_pop_value (popped value, zero otherwise).
//
// An accepted item's link and data memory reads are registered; in the execute
// state, once the output register is free, the write-back is done and the
// result is loaded into the output register. The next item is taken only
// after the write-back, so reads never see stale entries.
//
// Reset puts every stack empty and the free list in slot order; the link
// memory is not swept, a high-water count stands in for the untouched slots.
// When the receiver stalls, a result waits in the output register while one
// more item is accepted; that item then holds in its execute cycle.
module multi_stack_shared_pool_top #(
    parameter int NUM_STACKS = msp_pkg::NUM_STACKS_DEF,
    parameter int CAPACITY   = msp_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_operation,
    input  logic [msp_pkg::SIDX_W-1:0]          i_stack_index,
    input  logic signed [msp_pkg::DATA_W-1:0]   i_push_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [msp_pkg::STATUS_W-1:0]        o_status,
    output logic signed [msp_pkg::DATA_W-1:0]   o_pop_value
);

    localparam int AW     = $clog2(CAPACITY);
    localparam int LW     = $clog2(CAPACITY + 1);
    localparam int TOP_AW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam logic [LW-1:0] NULL_LINK = LW'(CAPACITY);

    msp_pkg::t_state r_state;
    msp_pkg::t_state n_state;

    // Control state
    logic [LW-1:0] r_top [NUM_STACKS];
    logic [LW-1:0] r_free_head;
    logic [LW-1:0] r_hwm;
    logic          r_out_valid;

    // Item in flight
    logic                        r_op;
    logic [TOP_AW-1:0]           r_idx;
    logic [msp_pkg::DATA_W-1:0]  r_value;
    logic [LW-1:0]               r_addr;
    logic                        r_refused;

    // Output payload
    logic [msp_pkg::STATUS_W-1:0] r_status;
    logic [msp_pkg::DATA_W-1:0]   r_pop_value;

    logic                        w_accept;
    logic                        w_done;
    logic [31:0]                 w_sidx32;
    logic [TOP_AW-1:0]           w_idx;
    logic                        w_idx_ok;
    logic [LW-1:0]               w_top_cur;
    logic [LW-1:0]               w_addr;
    logic                        w_refused;
    logic [LW-1:0]               w_link_rd;
    logic [LW-1:0]               w_link;
    logic [msp_pkg::DATA_W-1:0]  w_data_rd;
    logic                        w_link_we;
    logic [LW-1:0]               w_link_wdata;
    logic                        w_data_we;

    assign o_in_ready = (r_state == msp_pkg::S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_done     = (r_state == msp_pkg::S_EXEC) && (!r_out_valid || i_out_ready);

    // Decode the addressed stack and pick the slot to touch
    assign w_sidx32  = 32'(i_stack_index);
    assign w_idx     = w_sidx32[TOP_AW-1:0];
    assign w_idx_ok  = (w_sidx32 < 32'(NUM_STACKS));
    assign w_top_cur = r_top[w_idx];

    always_comb begin
        if (i_operation == msp_pkg::OP_PUSH) begin
            w_addr    = r_free_head;
            w_refused = !w_idx_ok || (r_free_head >= NULL_LINK);
        end else begin
            w_addr    = w_top_cur;
            w_refused = !w_idx_ok || (w_top_cur >= NULL_LINK);
        end
    end

    // Slots at or above the high-water mark were never written: they link to the next slot
    assign w_link = (r_addr < r_hwm) ? w_link_rd : (r_addr + LW'(1));

    assign w_link_we    = w_done && !r_refused;
    assign w_data_we    = w_link_we && (r_op == msp_pkg::OP_PUSH);
    assign w_link_wdata = (r_op == msp_pkg::OP_PUSH) ? r_top[r_idx] : r_free_head;

    msp_ram #(
        .WIDTH (LW),
        .DEPTH (CAPACITY)
    ) u_link_mem (
        .i_clk   (i_clk),
        .i_we    (w_link_we),
        .i_waddr (r_addr[AW-1:0]),
        .i_wdata (w_link_wdata),
        .i_re    (w_accept),
        .i_raddr (w_addr[AW-1:0]),
        .o_rdata (w_link_rd)
    );

    msp_ram #(
        .WIDTH (msp_pkg::DATA_W),
        .DEPTH (CAPACITY)
    ) u_data_mem (
        .i_clk   (i_clk),
        .i_we    (w_data_we),
        .i_waddr (r_addr[AW-1:0]),
        .i_wdata (r_value),
        .i_re    (w_accept),
        .i_raddr (w_addr[AW-1:0]),
        .o_rdata (w_data_rd)
    );

    // Sequence: read on accept, write back when the output register is free
    always_comb begin
        n_state = r_state;
        case (r_state)
            msp_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = msp_pkg::S_EXEC;
                end
            end
            msp_pkg::S_EXEC: begin
                if (w_done) begin
                    n_state = msp_pkg::S_IDLE;
                end
            end
            default: n_state = msp_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= msp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the item in flight
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op      <= i_operation;
            r_idx     <= w_idx;
            r_value   <= i_push_value;
            r_addr    <= w_addr;
            r_refused <= w_refused;
        end
    end

    // Update stack tops, free head and high-water mark
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_STACKS; i++) begin
                r_top[i] <= NULL_LINK;
            end
            r_free_head <= '0;
            r_hwm       <= '0;
        end else if (w_link_we) begin
            if (r_op == msp_pkg::OP_PUSH) begin
                r_free_head  <= w_link;
                r_top[r_idx] <= r_addr;
                if (r_addr >= r_hwm) begin
                    r_hwm <= r_hwm + LW'(1);
                end
            end else begin
                r_top[r_idx] <= w_link;
                r_free_head  <= r_addr;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            if (r_refused) begin
                r_status    <= (r_op == msp_pkg::OP_PUSH) ? msp_pkg::ST_FULL
                                                          : msp_pkg::ST_EMPTY;
                r_pop_value <= '0;
            end else begin
                r_status    <= msp_pkg::ST_DONE;
                r_pop_value <= (r_op == msp_pkg::OP_POP) ? w_data_rd : '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_pop_value = r_pop_value;

endmodule
